FILE: rtl/coe_pkg.sv
// Shared types and constants of the clock offset estimator.
// Depends on nothing; every other file imports it.
`default_nettype none

package coe_pkg;

  localparam logic [1:0] REQ_PING  = 2'd0;
  localparam logic [1:0] REQ_PONG  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic CFG_WEIGHT = 1'b0;
  localparam logic CFG_DELAY  = 1'b1;

  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd6554;
  localparam logic [7:0]  DELAY_RESET  = 8'd2;

  typedef struct packed {
    logic [16:0] weight;
    logic [7:0]  delay;
  } cfg_t;

  typedef struct packed {
    logic [31:0] cli_tick;
    logic [31:0] rx_tick;
    logic [31:0] srv_tick;
    logic [31:0] tx_tick;
    logic [1:0]  req_type;
  } req_t;

  typedef struct packed {
    logic [31:0]        scheduled_tick;
    logic               offset_known;
    logic signed [31:0] offset_now;
    logic [31:0]        round_trip;
    logic               pong_accepted;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/coe_tracker.sv
// Exchange state, offset filter and schedule translation of the estimator.
// Depends on coe_pkg.
`default_nettype none

module coe_tracker
  import coe_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire req_t item,
  input  wire cfg_t cfg,
  output res_t      res
);

  localparam int TW = (TICK_BITS > 32) ? 32 : TICK_BITS;
  localparam logic [32:0] TMASK_W = (33'd1 << TW) - 33'd1;
  localparam logic [31:0] TMASK = TMASK_W[31:0];

  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    logic signed [31:0] r;
    if (v > 53'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic                 ping_pending_r, ping_pending_nxt;
  logic [TW-1:0]        pending_tick_r, pending_tick_nxt;
  logic [TW-1:0]        rtt_r, rtt_nxt;
  logic                 offset_valid_r, offset_valid_nxt;
  logic signed [31:0]   offset_est_r, offset_est_nxt;

  logic [TW-1:0]        sent_m, server_m, recv_m, client_m;
  logic                 hit;
  logic [TW-1:0]        rtt;
  logic signed [34:0]   sample;
  logic signed [34:0]   diff;
  logic [16:0]          w;
  logic signed [17:0]   w_s;
  logic signed [52:0]   prod;
  logic signed [52:0]   acc;
  logic signed [52:0]   rnd;
  logic signed [34:0]   sched_sum;
  logic [31:0]          sched;

  assign sent_m   = item.tx_tick[TW-1:0];
  assign server_m = item.srv_tick[TW-1:0];
  assign recv_m   = item.rx_tick[TW-1:0];
  assign client_m = item.cli_tick[TW-1:0];

  assign hit = (item.req_type == REQ_PONG) && ping_pending_r &&
               (pending_tick_r == sent_m) && (recv_m >= sent_m);
  assign rtt = recv_m - sent_m;

  // The blend w*s + (1-w)*old is formed as w*(s-old) + old*2^16, one multiply.
  assign sample = $signed(35'(server_m) + 35'(rtt >> 1) - 35'(recv_m));
  assign diff   = sample - 35'(offset_est_r);
  assign w      = (cfg.weight > ONE_Q16) ? ONE_Q16 : cfg.weight;
  assign w_s    = $signed({1'b0, w});
  assign prod   = 53'(diff) * 53'(w_s);
  assign acc    = prod + (53'(offset_est_r) <<< 16);
  assign rnd    = (acc + (acc[52] ? 53'sd32767 : 53'sd32768)) >>> 16;

  assign sched_sum = $signed(35'(client_m)) + 35'(offset_est_r) + $signed(35'(cfg.delay));

  always_comb begin
    if (sched_sum[34]) begin
      sched = '0;
    end else if (sched_sum[33:0] > 34'(TMASK)) begin
      sched = TMASK;
    end else begin
      sched = sched_sum[31:0];
    end
  end

  always_comb begin
    ping_pending_nxt = ping_pending_r;
    pending_tick_nxt = pending_tick_r;
    rtt_nxt          = rtt_r;
    offset_valid_nxt = offset_valid_r;
    offset_est_nxt   = offset_est_r;
    if (item.req_type == REQ_PING) begin
      ping_pending_nxt = 1'b1;
      pending_tick_nxt = sent_m;
    end else if (hit) begin
      ping_pending_nxt = 1'b0;
      rtt_nxt          = rtt;
      offset_valid_nxt = 1'b1;
      offset_est_nxt   = offset_valid_r ? sat32(rnd) : sat32(53'(sample));
    end
  end

  always_comb begin
    res.pong_accepted  = hit;
    res.round_trip     = 32'(rtt_nxt);
    res.offset_now     = offset_est_nxt;
    res.offset_known   = offset_valid_nxt;
    res.scheduled_tick = (item.req_type == REQ_QUERY) ? sched : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_pending_r <= 1'b0;
      pending_tick_r <= '0;
      rtt_r          <= '0;
      offset_valid_r <= 1'b0;
      offset_est_r   <= '0;
    end else if (en) begin
      ping_pending_r <= ping_pending_nxt;
      pending_tick_r <= pending_tick_nxt;
      rtt_r          <= rtt_nxt;
      offset_valid_r <= offset_valid_nxt;
      offset_est_r   <= offset_est_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    offset_valid_r |=> offset_valid_r)
    else $error("offset estimate lost its valid flag");

  a_zero_until_known: assert property (@(posedge clk) disable iff (!rst_n)
    !offset_valid_r |-> (offset_est_r == 32'sd0))
    else $error("offset estimate nonzero before the first sample");

  a_pong_clears_ping: assert property (@(posedge clk) disable iff (!rst_n)
    (en && hit) |=> (!ping_pending_r && offset_valid_r))
    else $error("accepted pong did not clear the pending ping");
`endif

endmodule

`default_nettype wire

FILE: rtl/clock_offset_estimator_unit.sv
// Clock offset estimator: stream wrapper with configuration registers,
// input register and result register. Depends on coe_pkg and coe_tracker.
//
// Usage: each input transfer carries one request (ping sent, pong received or
// schedule query) and produces exactly one result transfer, in order.
// in_tuser holds the request type; in_tdata holds the four tick fields.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while the
// block is idle; index 0 is the smoothing weight, index 1 the input delay.
// A request taken into the input register moves on to the result register,
// which drives out_tvalid, once that register is empty or being read.
// Throughput: one request per cycle while out_tready is high; the offset
// filter and exchange state are updated as a request moves from the
// input register to the result register.
// A stalled receiver holds the result register; one more request is taken
// into the input register, after which in_tready drops.
// Reset (synchronous, rst_n low) empties both registers, clears the pending
// ping, round trip and offset, and loads the default weight and delay.
`default_nettype none

module clock_offset_estimator_unit
  import coe_pkg::*;
#(
  parameter int TICK_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_index,
  input  wire logic [16:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: tx_tick, srv_tick, rx_tick, cli_tick
  input  wire logic [127:0] in_tdata,
  // tuser: req_type
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: pong_accepted, round_trip, offset_now, offset_known,
  // scheduled_tick, then zero padding
  output logic [103:0]      out_tdata
);

  cfg_t         cfg_r;
  req_t         item_r;
  logic         item_valid_r, item_valid_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [103:0] out_data_r;
  logic         in_fire;
  logic         advance;
  res_t         res;

  assign advance   = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_fire) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weight <= WEIGHT_RESET;
      cfg_r.delay  <= DELAY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WEIGHT: cfg_r.weight <= cfg_wdata;
        CFG_DELAY:  cfg_r.delay  <= cfg_wdata[7:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.req_type <= in_tuser;
      item_r.tx_tick  <= in_tdata[31:0];
      item_r.srv_tick <= in_tdata[63:32];
      item_r.rx_tick  <= in_tdata[95:64];
      item_r.cli_tick <= in_tdata[127:96];
    end
    if (advance) begin
      out_data_r <= {6'd0, res.scheduled_tick, res.offset_known, res.offset_now,
                     res.round_trip, res.pong_accepted};
    end
  end

  coe_tracker #(
    .TICK_BITS(TICK_BITS)
  ) u_tracker (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (advance),
    .item (item_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_buffered_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && out_valid_r && !out_tready) |=> item_valid_r)
    else $error("buffered request dropped while the result was stalled");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request produced no result");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |-> in_tready)
    else $error("input not ready while the input register is empty");
`endif

endmodule

`default_nettype wire

FILE: tb/clock_offset_estimator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the clock offset estimator: it tracks the configuration and
// exchange state, predicts each result and compares every output transfer.
// Depends on coe_pkg for the request codes, register indexes and result layout.

module clock_offset_estimator_checker
  import coe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [16:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  output int           fail_count,
  output int           outstanding
);

  localparam longint HALF_Q16   = 32768;
  localparam longint TICK_MAX   = 64'hFFFF_FFFF;
  localparam longint OFFSET_MAX = 64'sd2147483647;
  localparam longint OFFSET_MIN = -64'sd2147483648;

  logic [16:0]        weight;
  logic [7:0]         delay;
  bit                 ping_pending;
  logic [31:0]        pending_sent;
  logic [31:0]        rtt_last;
  bit                 offset_valid;
  logic signed [31:0] offset_est;

  res_t expected_results[$];
  res_t got;
  res_t want;
  int   mismatches = 0;
  int   waiting = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  function automatic logic signed [31:0] clamp_offset(input longint v);
    if (v > OFFSET_MAX) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < OFFSET_MIN) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Applies one request to the tracked state and returns the result it causes.
  function automatic res_t advance_estimator(input logic [1:0] kind, input logic [31:0] sent,
                                             input logic [31:0] server, input logic [31:0] recv,
                                             input logic [31:0] client);
    res_t        r;
    logic [31:0] rtt;
    longint      sample;
    longint      half_rtt;
    longint      recv_l;
    longint      w;
    longint      keep;
    longint      old;
    longint      acc;
    longint      blended;
    longint      sched;
    r = '0;
    sched = 0;
    case (kind)
      REQ_PING: begin
        ping_pending = 1'b1;
        pending_sent = sent;
      end
      REQ_PONG: begin
        if (ping_pending && pending_sent == sent && recv >= sent) begin
          rtt = recv - sent;
          sample = longint'(server);
          half_rtt = longint'(rtt >> 1);
          recv_l = longint'(recv);
          sample = sample + half_rtt - recv_l;
          ping_pending = 1'b0;
          rtt_last = rtt;
          r.pong_accepted = 1'b1;
          if (!offset_valid) begin
            offset_est = clamp_offset(sample);
            offset_valid = 1'b1;
          end else begin
            w = longint'(weight);
            if (w > longint'(ONE_Q16)) begin
              w = longint'(ONE_Q16);
            end
            keep = longint'(ONE_Q16);
            keep = keep - w;
            old = longint'(offset_est);
            acc = w * sample + keep * old;
            if (acc >= 0) begin
              blended = (acc + HALF_Q16) >>> 16;
            end else begin
              blended = -((-acc + HALF_Q16) >>> 16);
            end
            offset_est = clamp_offset(blended);
          end
        end
      end
      REQ_QUERY: begin
        sched = longint'(client);
        if (offset_valid) begin
          old = longint'(offset_est);
          sched = sched + old;
        end
        sched = sched + longint'(delay);
        if (sched < 0) begin
          sched = 0;
        end
        if (sched > TICK_MAX) begin
          sched = TICK_MAX;
        end
      end
      default: begin
      end
    endcase
    r.round_trip     = rtt_last;
    r.offset_now     = offset_valid ? offset_est : 32'sd0;
    r.offset_known   = offset_valid;
    r.scheduled_tick = sched[31:0];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      weight = WEIGHT_RESET;
      delay = DELAY_RESET;
      ping_pending = 1'b0;
      pending_sent = '0;
      rtt_last = '0;
      offset_valid = 1'b0;
      offset_est = '0;
      expected_results.delete();
      waiting <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_WEIGHT) begin
          weight = cfg_wdata;
        end else begin
          delay = cfg_wdata[7:0];
        end
      end
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[97:0]);
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding: 0x%h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("pong_accepted", 32'(want.pong_accepted), 32'(got.pong_accepted));
          compare_field("round_trip", want.round_trip, got.round_trip);
          compare_field("offset_now", want.offset_now, got.offset_now);
          compare_field("offset_known", 32'(want.offset_known), 32'(got.offset_known));
          compare_field("scheduled_tick", want.scheduled_tick, got.scheduled_tick);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(advance_estimator(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                                     in_tdata[95:64], in_tdata[127:96]));
      end
      waiting <= expected_results.size();
    end
  end

endmodule

FILE: tb/clock_offset_estimator_unit_test.sv
`timescale 1ns / 100ps
// Top of the clock offset estimator testbench: clock, reset, configuration,
// request stimulus and result back-pressure. Depends on coe_pkg, the unit and
// clock_offset_estimator_checker, which predicts and compares the results.

module clock_offset_estimator_unit_test;
  import coe_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_index = 1'b0;
  logic [16:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  wire          in_tready;
  // tdata: tx_tick, srv_tick, rx_tick, cli_tick
  logic [127:0] in_tdata = '0;
  // tuser: req_type
  logic [1:0]   in_tuser = '0;
  wire          out_tvalid;
  logic         out_tready = 1'b0;
  // tdata: pong_accepted, round_trip, offset_now, offset_known, scheduled_tick
  wire  [103:0] out_tdata;

  int fail_count;
  int outstanding;
  int send_idle_pct = 35;
  int recv_idle_pct = 51;
  int stall_req = 0;
  int items_sent = 0;

  clock_offset_estimator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  clock_offset_estimator_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result back-pressure; a stall request holds the output off for a long stretch.
  initial begin
    int hold_left;
    int stalls_served;
    hold_left = 0;
    stalls_served = 0;
    forever begin
      @(posedge clk);
      if (stall_req != stalls_served) begin
        stalls_served = stall_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] kind, input logic [31:0] sent,
                           input logic [31:0] server, input logic [31:0] recv,
                           input logic [31:0] client);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {client, recv, server, sent};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic send_ping(input logic [31:0] tick);
    send_item(REQ_PING, tick, $urandom, $urandom, $urandom);
  endtask

  task automatic send_pong(input logic [31:0] sent, input logic [31:0] server,
                           input logic [31:0] recv);
    send_item(REQ_PONG, sent, server, recv, $urandom);
  endtask

  task automatic send_query(input logic [31:0] client);
    send_item(REQ_QUERY, $urandom, $urandom, $urandom, client);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [16:0] weight, input logic [7:0] delay);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_WEIGHT;
    cfg_wdata <= weight;
    @(posedge clk);
    cfg_index <= CFG_DELAY;
    cfg_wdata <= {9'd0, delay};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_client();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // One ping/pong exchange with random content, sometimes broken on purpose.
  task automatic random_exchange();
    logic [31:0] t;
    logic [31:0] recv;
    logic [31:0] server;
    int          pick;
    pick = $urandom_range(99);
    t = $urandom;
    if (pick < 10) begin
      send_ping($urandom);
    end
    send_ping(t);
    repeat ($urandom_range(0, 2)) send_query(pick_client());
    case ($urandom_range(9))
      0: recv = t;
      1: recv = t + $urandom;
      default: recv = t + $urandom_range(1, 5000);
    endcase
    if ($urandom_range(3) == 0) begin
      server = $urandom;
    end else begin
      server = recv + $urandom_range(0, 2097152) - 32'd1048576;
    end
    if (pick >= 90) begin
      send_pong(t ^ (32'd1 << $urandom_range(31)), server, recv);
    end else if (pick >= 82) begin
      send_pong(t, server, t - $urandom_range(1, 5000));
    end else begin
      send_pong(t, server, recv);
    end
    send_query(pick_client());
  endtask

  initial begin
    logic [16:0] weight_plan [8];
    logic [7:0]  delay_plan [8];
    int          phase_end;
    weight_plan = '{17'd0, ONE_Q16, 17'h1FFFF, WEIGHT_RESET, 17'd1, 17'd32768, 17'd65535,
                    17'd40000};
    delay_plan  = '{8'd255, 8'd0, 8'd128, DELAY_RESET, 8'd1, 8'd77, 8'd200, 8'd3};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_query('0);
    send_query('1);
    send_pong('0, '0, '0);
    send_item(REQ_UNUSED, '1, '1, '1, '1);
    send_ping(32'd100);
    send_pong(32'd99, 32'd300, 32'd200);
    send_pong(32'd100, 32'd300, 32'd50);
    send_ping(32'd1000);
    send_pong(32'd100, 32'd300, 32'd200);
    send_pong(32'd1000, '1, 32'd1010);
    send_query('0);
    send_query('1);
    wait_idle();
    set_cfg(ONE_Q16, 8'd255);
    send_ping('1);
    send_pong('1, '0, '1);
    send_query('0);
    send_query('1);
    send_ping('0);
    send_pong('0, '1, '0);
    send_ping('0);
    send_pong('0, '0, '1);
    wait_idle();
    set_cfg(17'h1FFFF, 8'd0);
    send_ping(32'd5);
    send_pong(32'd5, 32'd12345, 32'd77);
    send_query(32'd1000);
    wait_idle();
    set_cfg(17'd0, 8'd128);
    send_ping(32'd7);
    send_pong(32'd7, 32'h8000_0000, 32'd9);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (p == 7) begin
        weight_plan[p] = 17'($urandom_range(0, 131071));
        delay_plan[p] = 8'($urandom_range(0, 255));
      end
      set_cfg(weight_plan[p], delay_plan[p]);
      if (p < 3) begin
        send_idle_pct = 35;
        recv_idle_pct = 51;
      end else if (p < 6) begin
        send_idle_pct = 51;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 6) begin
        stall_req++;
      end
      phase_end = items_sent + 200;
      while (items_sent < phase_end) begin
        if ($urandom_range(9) == 0) begin
          send_item(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
        end else begin
          random_exchange();
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
